FILE: src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the sorted table search
// Sequencer states, function codes, register map and fixed field widths.
// ----------------------------------------------------------------------------
package sts_pkg;

    // fixed field widths of the transfer payloads
    localparam int FUNC_W  = 1;
    localparam int INDEX_W = 10;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;

    // register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_ENTRY_COUNT = 3'd0;

    // function codes of an input transfer
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

    // search sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

endpackage

FILE: src/sts_ram.sv
// ----------------------------------------------------------------------------
// sts_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search: binary search over a table held in RAM
// Write transfers fill table entries; search transfers halve the window over
// the first entry_count entries and return found flag and position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries i_func, i_entry_index and
//   i_data_value. A write transfer stores one entry and gives no result;
//   writes at or above DEPTH are dropped. A search transfer gives exactly
//   one result on the output channel (o_valid/i_ready) with o_found and
//   o_position (0 on a miss).
//   entry_count is set over the APB port at address 0, to be written only
//   while the block is idle (the user's duty; the block does not enforce it);
//   values above DEPTH search the whole table.
//   Each probe of a search issues the RAM read in S_READ and compares the
//   registered read data in S_CMP. A hit goes from S_CMP to S_DONE; a miss
//   reaches S_DONE from S_READ once the window is empty. A search makes at
//   most clog2(min(entry_count, DEPTH)+1) probes. o_ready stays low until
//   the result is loaded, so one search runs at a time.
//   The result sits in an output register: while the receiver stalls, new
//   writes are taken, and a finished second search holds in its final state
//   until the register frees up.
//   Reset clears entry_count to 0 and the control state; table contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [sts_pkg::FUNC_W-1:0]           i_func,
    input  logic [sts_pkg::INDEX_W-1:0]          i_entry_index,
    input  logic signed [sts_pkg::DATA_W-1:0]    i_data_value,
    // result channel
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_found,
    output logic [sts_pkg::INDEX_W-1:0]          o_position,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sts_pkg::PADDR_W-1:0]          paddr,
    input  logic [sts_pkg::PDATA_W-1:0]          pwdata,
    output logic [sts_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = (CW > sts_pkg::COUNT_W) ? CW : sts_pkg::COUNT_W;
    localparam int IW = (CW > sts_pkg::INDEX_W) ? CW : sts_pkg::INDEX_W;

    sts_pkg::t_state r_state, n_state;

    logic [sts_pkg::COUNT_W-1:0] r_entry_count;
    logic [CW-1:0]               r_lo, n_lo;
    logic [CW-1:0]               r_hi, n_hi;
    logic [CW-1:0]               r_mid, n_mid;
    logic [VALUE_WIDTH-1:0]      r_key, n_key;
    logic                        r_found, n_found;
    logic [CW-1:0]               r_pos, n_pos;
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_found, n_out_found;
    logic [sts_pkg::INDEX_W-1:0] r_out_pos, n_out_pos;

    logic                   w_in_xfer;
    logic                   w_out_free;
    logic                   w_cfg_wr;
    logic                   w_sel_count;
    logic [CW-1:0]          w_count;
    logic [CW-1:0]          w_mid;
    logic                   w_window_open;
    logic                   w_ram_we;
    logic                   w_ram_re;
    logic [VALUE_WIDTH-1:0] w_rd_data;
    logic                   w_probe_eq;
    logic                   w_probe_lt;

    // register port, decoded by word index
    assign pready      = 1'b1;
    assign w_cfg_wr    = psel && penable && pwrite && pready;
    assign w_sel_count = (paddr[sts_pkg::PADDR_W-1:2] ==
                          sts_pkg::REG_ENTRY_COUNT[sts_pkg::PADDR_W-1:2]);
    assign prdata      = w_sel_count ? sts_pkg::PDATA_W'(r_entry_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (w_cfg_wr && w_sel_count) begin
            r_entry_count <= pwdata[sts_pkg::COUNT_W-1:0];
        end
    end

    // clamp the count to the table size
    assign w_count = (NW'(r_entry_count) > NW'(DEPTH)) ? CW'(DEPTH) : CW'(r_entry_count);

    // handshakes
    assign o_ready    = (r_state == sts_pkg::S_IDLE);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    // window midpoint, valid while lo < hi
    assign w_window_open = (r_lo < r_hi);
    assign w_mid         = r_lo + ((r_hi - r_lo - CW'(1)) >> 1);

    // table writes and probe reads
    assign w_ram_we = w_in_xfer && (i_func == sts_pkg::FUNC_WRITE) &&
                      (IW'(i_entry_index) < IW'(DEPTH));
    assign w_ram_re = (r_state == sts_pkg::S_READ) && w_window_open;

    sts_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (VALUE_WIDTH'(i_data_value)),
        .i_re    (w_ram_re),
        .i_raddr (w_mid[AW-1:0]),
        .o_rdata (w_rd_data)
    );

    // probe compare, signed
    assign w_probe_eq = (w_rd_data == r_key);
    assign w_probe_lt = ($signed(w_rd_data) < $signed(r_key));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sts_pkg::S_IDLE: begin
                if (w_in_xfer && i_func == sts_pkg::FUNC_SEARCH) begin
                    n_state = sts_pkg::S_READ;
                end
            end
            sts_pkg::S_READ: begin
                n_state = w_window_open ? sts_pkg::S_CMP : sts_pkg::S_DONE;
            end
            sts_pkg::S_CMP: begin
                n_state = w_probe_eq ? sts_pkg::S_DONE : sts_pkg::S_READ;
            end
            sts_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = sts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sts_pkg::S_IDLE;
            end
        endcase
    end

    // search datapath and result register
    always_comb begin
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key       = r_key;
        n_found     = r_found;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !i_ready;
        n_out_found = r_out_found;
        n_out_pos   = r_out_pos;
        case (r_state)
            sts_pkg::S_IDLE: begin
                if (w_in_xfer && i_func == sts_pkg::FUNC_SEARCH) begin
                    n_key   = VALUE_WIDTH'(i_data_value);
                    n_lo    = '0;
                    n_hi    = w_count;
                    n_found = 1'b0;
                    n_pos   = '0;
                end
            end
            sts_pkg::S_READ: begin
                n_mid = w_mid;
            end
            sts_pkg::S_CMP: begin
                if (w_probe_eq) begin
                    n_found = 1'b1;
                    n_pos   = r_mid;
                end else if (w_probe_lt) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
            end
            sts_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_pos   = r_found ? sts_pkg::INDEX_W'(r_pos) : '0;
                end
            end
            default: begin
                n_found = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sts_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_key       <= n_key;
        r_found     <= n_found;
        r_pos       <= n_pos;
        r_out_found <= n_out_found;
        r_out_pos   <= n_out_pos;
    end

    assign o_valid    = r_out_valid;
    assign o_found    = r_out_found;
    assign o_position = r_out_pos;

`ifndef NO_ASSERTIONS
    // a compare always follows the read it checks
    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sts_pkg::S_CMP |-> $past(r_state) == sts_pkg::S_READ)
        else $error("compare without a preceding read");

    // window stays ordered and inside the table
    a_window_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sts_pkg::S_READ || r_state == sts_pkg::S_CMP) |->
        (r_lo <= r_hi && NW'(r_hi) <= NW'(DEPTH)))
        else $error("search window out of bounds");

    // probe lies inside the window
    a_mid_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sts_pkg::S_CMP |-> (r_mid >= r_lo && r_mid < r_hi))
        else $error("probe outside window");

    // a miss reports position zero
    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> o_position == '0)
        else $error("miss with nonzero position");

    // a new result only comes out of the final search state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid && !i_ready)) |-> $past(r_state) == sts_pkg::S_DONE)
        else $error("result loaded outside final state");
`endif

endmodule
